// ----- rtl/core/fgcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Frost-guarded cooling control package
// Shared types, register indexes, mode codes and reset values for the
// frost-guarded cooling controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fgcc_pkg;

  // Default design parameters.
  localparam int DEBOUNCE_SAMPLES_DEF = 5;
  localparam int WARMUP_BITS_DEF      = 16;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Field widths.
  localparam int TEMP_W = 12;
  localparam int BAND_W = 9;
  localparam int TICK_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTROL_MODE  = 3'd0,
    REG_MANUAL_PUMP   = 3'd1,
    REG_MANUAL_FAN    = 3'd2,
    REG_FROST_LIMIT   = 3'd3,
    REG_WARMUP_TICKS  = 3'd4,
    REG_ROOM_SETPOINT = 3'd5,
    REG_BAND_HIGH     = 3'd6,
    REG_BAND_LOW      = 3'd7
  } cfg_idx_t;

  // Control modes.
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_THERMO = 2'd2,
    MODE_REMOTE = 2'd3
  } mode_t;

  // Register reset values.
  localparam mode_t              MODE_RST          = MODE_THERMO;
  localparam logic signed [11:0] FROST_LIMIT_RST   = 12'sd450;
  localparam logic [15:0]        WARMUP_TICKS_RST  = 16'd600;
  localparam logic signed [11:0] ROOM_SETPOINT_RST = 12'sd650;
  localparam logic [8:0]         BAND_HIGH_RST     = 9'd20;
  localparam logic [8:0]         BAND_LOW_RST      = 9'd20;

  // One control sample.
  typedef struct packed {
    logic signed [TEMP_W-1:0] coil_temp;
    logic signed [TEMP_W-1:0] room_temp;
    logic                     thermostat_call;
    logic                     unit_led_on;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic              pump_on;
    logic              fan_on;
    logic              frost_detected;
    logic              frost_fault;
    logic              cool_enabled;
    logic [TICK_W-1:0] warmup_left;
  } out_item_t;

  // Frost protection status handed to the relay logic and the result.
  typedef struct packed {
    logic              frost_seen;
    logic              fault;
    logic              cool;
    logic [TICK_W-1:0] warmup_left;
  } frost_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/fgcc_frost.sv -----
// ----------------------------------------------------------------------------
// Frost detector and warm-up timer
// Debounces the coil frost condition, latches the frost fault and runs the
// warm-up countdown that gates re-enabling of cooling.
// ----------------------------------------------------------------------------
`default_nettype none

module fgcc_frost #(
  parameter int DEBOUNCE_SAMPLES = fgcc_pkg::DEBOUNCE_SAMPLES_DEF,
  parameter int WARMUP_BITS      = fgcc_pkg::WARMUP_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               step,
  input  wire logic signed [fgcc_pkg::TEMP_W-1:0] coil_temp,
  input  wire logic signed [fgcc_pkg::TEMP_W-1:0] frost_limit,
  input  wire logic        [fgcc_pkg::TICK_W-1:0] warmup_ticks,
  output fgcc_pkg::frost_sts_t                     sts_nxt
);

  localparam int DBW = $clog2(DEBOUNCE_SAMPLES + 1);
  localparam logic [DBW-1:0] DEB_SEED = DBW'(DEBOUNCE_SAMPLES);

  logic [DBW-1:0]         deb_cnt_r, deb_cnt_nxt, deb_dec;
  logic                   last_frost_r;
  logic                   seen_r, seen_nxt;
  logic                   fault_r, fault_nxt;
  logic                   cool_r, cool_nxt;
  logic                   retry_r, retry_nxt;
  logic [WARMUP_BITS-1:0] warm_r, warm_nxt, warm_load;
  logic                   frost;
  logic [WARMUP_BITS+15:0] ticks_ext, left_ext;

  // Raw frost condition and warm-up length fitted to the counter width.
  assign frost     = coil_temp <= frost_limit;
  assign ticks_ext = {{WARMUP_BITS{1'b0}}, warmup_ticks};
  assign warm_load = ticks_ext[WARMUP_BITS-1:0];

  // Debounce, then fault and warm-up handling for this sample.
  always_comb begin
    seen_nxt  = seen_r;
    fault_nxt = fault_r;
    cool_nxt  = cool_r;
    retry_nxt = retry_r;
    warm_nxt  = warm_r;
    deb_dec   = deb_cnt_r;

    if (deb_cnt_r != '0) begin
      deb_dec = deb_cnt_r - 1'b1;
      if (deb_dec == '0) begin
        if (frost) begin
          fault_nxt = 1'b1;
          seen_nxt  = 1'b1;
        end else begin
          seen_nxt = 1'b0;
        end
      end
    end
    deb_cnt_nxt = (last_frost_r != frost) ? DEB_SEED : deb_dec;

    if (seen_nxt) begin
      if (!retry_r) begin
        cool_nxt = 1'b0;
      end
      retry_nxt = 1'b1;
      warm_nxt  = warm_load;
    end else if (!retry_r || warm_r == '0) begin
      retry_nxt = 1'b0;
      warm_nxt  = '0;
      if (!cool_r) begin
        cool_nxt  = 1'b1;
        fault_nxt = 1'b0;
      end
    end else begin
      warm_nxt = warm_r - 1'b1;
    end
  end

  // The reported count is the counter seen through a 16-bit window.
  assign left_ext = {16'd0, warm_nxt};

  assign sts_nxt.frost_seen  = seen_nxt;
  assign sts_nxt.fault       = fault_nxt;
  assign sts_nxt.cool        = cool_nxt;
  assign sts_nxt.warmup_left = retry_nxt ? left_ext[15:0] : 16'd0;

  // State advances once per accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_cnt_r    <= '0;
      last_frost_r <= 1'b0;
      seen_r       <= 1'b0;
      fault_r      <= 1'b0;
      cool_r       <= 1'b0;
      retry_r      <= 1'b0;
      warm_r       <= '0;
    end else if (step) begin
      deb_cnt_r    <= deb_cnt_nxt;
      last_frost_r <= frost;
      seen_r       <= seen_nxt;
      fault_r      <= fault_nxt;
      cool_r       <= cool_nxt;
      retry_r      <= retry_nxt;
      warm_r       <= warm_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fgcc_relay.sv -----
// ----------------------------------------------------------------------------
// Pump and fan relay logic
// Drives the pump and fan relays from the control mode, the thermostat
// demand, the remote hysteresis band and the frost fault.
// ----------------------------------------------------------------------------
`default_nettype none

module fgcc_relay (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               step,
  input  wire fgcc_pkg::mode_t                    mode,
  input  wire logic                               manual_pump,
  input  wire logic                               manual_fan,
  input  wire logic                               fault,
  input  wire logic signed [fgcc_pkg::TEMP_W-1:0] room_temp,
  input  wire logic                               thermostat_call,
  input  wire logic                               unit_led_on,
  input  wire logic signed [fgcc_pkg::TEMP_W-1:0] room_setpoint,
  input  wire logic        [fgcc_pkg::BAND_W-1:0] band_high,
  input  wire logic        [fgcc_pkg::BAND_W-1:0] band_low,
  output logic                                    pump_nxt,
  output logic                                    fan_nxt
);

  localparam int SW = fgcc_pkg::TEMP_W + 2;

  logic                 pump_r;
  logic                 demand, pump_mid;
  logic signed [SW-1:0] room_ext, sp_ext, on_thr, off_thr;

  // Hysteresis thresholds in a width that cannot overflow.
  assign room_ext = SW'(room_temp);
  assign sp_ext   = SW'(room_setpoint);
  assign on_thr   = sp_ext + $signed({{(SW-fgcc_pkg::BAND_W){1'b0}}, band_high});
  assign off_thr  = sp_ext - $signed({{(SW-fgcc_pkg::BAND_W){1'b0}}, band_low});
  assign demand   = thermostat_call && unit_led_on;

  // Relay commands for this sample.
  always_comb begin
    pump_mid = pump_r;
    pump_nxt = 1'b0;
    fan_nxt  = 1'b0;
    case (mode)
      fgcc_pkg::MODE_MANUAL: begin
        pump_nxt = manual_pump;
        fan_nxt  = manual_fan;
      end
      fgcc_pkg::MODE_THERMO: begin
        pump_nxt = demand && !fault;
        fan_nxt  = demand || fault;
      end
      fgcc_pkg::MODE_REMOTE: begin
        fan_nxt = 1'b1;
        if (!fault && !pump_r && room_ext >= on_thr) begin
          pump_mid = 1'b1;
        end
        // Turn-off check sees a turn-on from the same sample.
        if (fault || (pump_mid && room_ext <= off_thr)) begin
          pump_nxt = 1'b0;
        end else begin
          pump_nxt = pump_mid;
        end
      end
      default: begin
        pump_nxt = 1'b0;
        fan_nxt  = 1'b0;
      end
    endcase
  end

  // Pump state advances once per accepted sample; only the pump uses history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_r <= 1'b0;
    end else if (step) begin
      pump_r <= pump_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/frost_guarded_cooling_control.sv -----
// ----------------------------------------------------------------------------
// Frost-guarded cooling control
// Per-sample frost debounce, fault latch with warm-up retry, and pump and
// fan relay control for a room air conditioner.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Ports                          Payload
// in        in         in_valid, in_stall, in_data    fgcc_pkg::in_item_t
// out       out        out_valid, out_stall, out_data fgcc_pkg::out_item_t
// cfg       in         cfg_we, cfg_idx, cfg_wdata     register write, no wait
//
// A request is taken into the input register; its result is computed there
// and loaded into the output register once that is free or being taken,
// one request per cycle sustained while the output is not stalled.
// A stalled output holds its result; the input register still takes a new
// request while the output is free or is being taken.
// Reset is synchronous and active low and clears all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module frost_guarded_cooling_control #(
  parameter int DEBOUNCE_SAMPLES = fgcc_pkg::DEBOUNCE_SAMPLES_DEF,
  parameter int WARMUP_BITS      = fgcc_pkg::WARMUP_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire fgcc_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output fgcc_pkg::out_item_t                        out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [fgcc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [fgcc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Configuration registers.
  fgcc_pkg::mode_t                        mode_r;
  logic                                   man_pump_r;
  logic                                   man_fan_r;
  logic signed [fgcc_pkg::TEMP_W-1:0]     frost_limit_r;
  logic        [fgcc_pkg::TICK_W-1:0]     warmup_ticks_r;
  logic signed [fgcc_pkg::TEMP_W-1:0]     setpoint_r;
  logic        [fgcc_pkg::BAND_W-1:0]     band_high_r;
  logic        [fgcc_pkg::BAND_W-1:0]     band_low_r;

  // Pipeline registers.
  logic                 a_vld_r;
  fgcc_pkg::in_item_t   a_data_r;
  fgcc_pkg::out_item_t  out_data_r;
  logic                 out_vld_r;

  logic                 step;
  fgcc_pkg::frost_sts_t sts_nxt;
  logic                 pump_nxt, fan_nxt;

  // Advance the held request when the output register is free or emptying.
  assign step     = a_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = a_vld_r && !step;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (!in_stall) begin
      a_vld_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      a_data_r <= in_data;
    end
  end

  // Frost detector and warm-up timer.
  fgcc_frost #(
    .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES),
    .WARMUP_BITS      (WARMUP_BITS)
  ) u_frost (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .coil_temp    (a_data_r.coil_temp),
    .frost_limit  (frost_limit_r),
    .warmup_ticks (warmup_ticks_r),
    .sts_nxt      (sts_nxt)
  );

  // Relay logic sees the fault as updated by this sample.
  fgcc_relay u_relay (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .mode            (mode_r),
    .manual_pump     (man_pump_r),
    .manual_fan      (man_fan_r),
    .fault           (sts_nxt.fault),
    .room_temp       (a_data_r.room_temp),
    .thermostat_call (a_data_r.thermostat_call),
    .unit_led_on     (a_data_r.unit_led_on),
    .room_setpoint   (setpoint_r),
    .band_high       (band_high_r),
    .band_low        (band_low_r),
    .pump_nxt        (pump_nxt),
    .fan_nxt         (fan_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
    if (step) begin
      out_data_r.pump_on        <= pump_nxt;
      out_data_r.fan_on         <= fan_nxt;
      out_data_r.frost_detected <= sts_nxt.frost_seen;
      out_data_r.frost_fault    <= sts_nxt.fault;
      out_data_r.cool_enabled   <= sts_nxt.cool;
      out_data_r.warmup_left    <= sts_nxt.warmup_left;
    end
  end

  // Configuration writes; manual commands drop whenever a sample runs outside
  // manual mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= fgcc_pkg::MODE_RST;
      man_pump_r     <= 1'b0;
      man_fan_r      <= 1'b0;
      frost_limit_r  <= fgcc_pkg::FROST_LIMIT_RST;
      warmup_ticks_r <= fgcc_pkg::WARMUP_TICKS_RST;
      setpoint_r     <= fgcc_pkg::ROOM_SETPOINT_RST;
      band_high_r    <= fgcc_pkg::BAND_HIGH_RST;
      band_low_r     <= fgcc_pkg::BAND_LOW_RST;
    end else begin
      if (step && mode_r != fgcc_pkg::MODE_MANUAL) begin
        man_pump_r <= 1'b0;
        man_fan_r  <= 1'b0;
      end
      if (cfg_we) begin
        case (fgcc_pkg::cfg_idx_t'(cfg_idx))
          fgcc_pkg::REG_CONTROL_MODE:  mode_r <= fgcc_pkg::mode_t'(cfg_wdata[1:0]);
          fgcc_pkg::REG_MANUAL_PUMP:   man_pump_r <= cfg_wdata[0];
          fgcc_pkg::REG_MANUAL_FAN:    man_fan_r <= cfg_wdata[0];
          fgcc_pkg::REG_FROST_LIMIT:   frost_limit_r <= $signed(cfg_wdata[11:0]);
          fgcc_pkg::REG_WARMUP_TICKS:  warmup_ticks_r <= cfg_wdata[15:0];
          fgcc_pkg::REG_ROOM_SETPOINT: setpoint_r <= $signed(cfg_wdata[11:0]);
          fgcc_pkg::REG_BAND_HIGH:     band_high_r <= cfg_wdata[8:0];
          fgcc_pkg::REG_BAND_LOW:      band_low_r <= cfg_wdata[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Cooling is never enabled while the frost fault is latched.
  a_cool_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.cool_enabled && out_data.frost_fault))
    else $error("cooling enabled with frost fault latched");

  // A running warm-up only exists under a latched fault.
  a_warmup_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.warmup_left != 16'd0 |-> out_data.frost_fault)
    else $error("warm-up running without frost fault");

  // Outside manual mode the pump never runs under a fault.
  a_pump_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pump_on && mode_r != fgcc_pkg::MODE_MANUAL
      |-> !out_data.frost_fault)
    else $error("pump on during frost fault");

  // The input side only stalls while a request is held.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a held request");

endmodule

`default_nettype wire
